### hdl/lbp_pkg.sv
// Shared types, constants and neighbour tables for the 3x3 local binary pattern block.
// No dependencies; every other file of the block imports this package.
package lbp_pkg;

  localparam int MAX_ROWS_DEF = 1024;

  localparam int PIX_W    = 8;
  localparam int ROWS_W   = 11;
  localparam int COLS_W   = 16;
  localparam int COLP_W   = COLS_W + 1;
  localparam int CNT_W    = 32;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam int ROWS_MIN = 3;
  localparam int COLS_MIN = 3;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd480;
  localparam logic [COLS_W-1:0] COLS_RESET = 16'd640;

  // Register indexes on the configuration port.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Iterative divider that re-derives the centre row and column.
  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Window layout: index = 3*(1+row offset) + (1+column offset), centre in the middle.
  localparam int NB_N       = 8;
  localparam int WIN_N      = 9;
  localparam int CENTRE_TAP = 4;
  localparam int TAP_W      = 4;

  // Window tap of neighbour n, from its (column,row) offset as (1+dr)*3+(1+dc).
  localparam logic [TAP_W-1:0] NB_TAP [NB_N] = '{
    4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0, 4'd1, 4'd2
  };

  // Neighbours that fall off each image edge.
  localparam logic [NB_N-1:0] NB_LEFT  = 8'b0011_1000;  // column offset -1
  localparam logic [NB_N-1:0] NB_RIGHT = 8'b1000_0011;  // column offset +1
  localparam logic [NB_N-1:0] NB_UP    = 8'b1110_0000;  // row offset -1
  localparam logic [NB_N-1:0] NB_DOWN  = 8'b0000_1110;  // row offset +1

  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [CNT_W-1:0]  total;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_st_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [NB_N-1:0]  mask;
    logic [PIX_W-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_en_t;

  typedef struct packed {
    logic v1;
    logic v2;
  } pipe_st_t;

endpackage

### hdl/lbp_regs.sv
// Configuration registers on the APB-style port, with saturated image size and pixel total.
// Depends on lbp_pkg.
module lbp_regs
  import lbp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int RW       = $clog2(MAX_ROWS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output logic               pready_o,
  output logic [RW-1:0]      rows_o,
  output cfg_t               cfg_o,
  output logic               wr_o
);

  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [CNT_W-1:0]  total_q;
  logic [RW-1:0]     rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic              idx;

  assign pready_o = 1'b1;
  assign idx      = paddr_i[PADDR_W-1];
  assign wr_o     = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (wr_o) begin
      case (idx)
        REG_ROWS: rows_q <= pwdata_i[ROWS_W-1:0];
        REG_COLS: cols_q <= pwdata_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS: prdata_o = PDATA_W'(rows_q);
      REG_COLS: prdata_o = PDATA_W'(cols_q);
      default:  prdata_o = '0;
    endcase
  end

  // Out-of-range sizes are clamped to what the datapath supports.
  always_comb begin
    if (rows_q < ROWS_W'(ROWS_MIN)) begin
      rows_eff = RW'(ROWS_MIN);
    end else if (CNT_W'(rows_q) > CNT_W'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(rows_q);
    end
    cols_eff = (cols_q < COLS_W'(COLS_MIN)) ? COLS_W'(COLS_MIN) : cols_q;
  end

  always_ff @(posedge clk_i) begin
    total_q <= CNT_W'(rows_eff) * CNT_W'(cols_eff);
  end

  assign rows_o      = rows_eff;
  assign cfg_o.cols  = cols_eff;
  assign cfg_o.total = total_q;

endmodule

### hdl/lbp_div.sv
// Restoring divider, one quotient bit per cycle, that splits the emitted count into column and row.
// Depends on lbp_pkg.
module lbp_div
  import lbp_pkg::*;
#(
  parameter int RW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [RW-1:0]    divisor_i,
  output div_st_t          st_o,
  output logic [CNT_W-1:0] quo_o,
  output logic [RW-1:0]    rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     dvd_q;
  logic [RW-1:0]        rem_q;
  logic [RW:0]          trial;
  logic [RW:0]          diff;

  assign trial = {rem_q, dvd_q[CNT_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  // The first busy cycle loads the operands, so a new divisor has settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      if (cnt_q == '0) begin
        dvd_q <= dividend_i;
        rem_q <= '0;
      end else if (!diff[RW]) begin
        rem_q <= diff[RW-1:0];
        dvd_q <= {dvd_q[CNT_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[RW-1:0];
        dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
      end
    end
  end

  assign st_o.busy = busy_q || done_q;
  assign st_o.done = done_q;
  assign quo_o     = dvd_q;
  assign rem_o     = rem_q;

endmodule

### hdl/lbp_seq.sv
// Scan sequencer: row and column position, fed and emitted counts, edge mask and frame end.
// Depends on lbp_pkg.
module lbp_seq
  import lbp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int RW       = $clog2(MAX_ROWS + 1),
  parameter int AW       = $clog2(MAX_ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             flush_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [RW-1:0]    rows_i,
  input  cfg_t             cfg_i,
  input  div_st_t          div_i,
  input  logic [CNT_W-1:0] quo_i,
  input  logic [RW-1:0]    rem_i,
  output logic [CNT_W-1:0] emitted_o,
  output logic             valid_o,
  output item_t            item_o,
  output logic [AW-1:0]    addr_o
);

  logic [AW-1:0]     row_q;
  logic [COLP_W-1:0] col_q;
  logic [CNT_W-1:0]  fed_q;
  logic [CNT_W-1:0]  emitted_q;
  logic [RW-1:0]     cr_q;
  logic [CNT_W-1:0]  cc_q;

  logic             in_frame;
  logic             process;
  logic [CNT_W-1:0] fed_n;
  logic [CNT_W-1:0] emitted_n;
  logic             emit;
  logic             last;
  logic             row_wrap;
  logic             first_col;
  logic             last_col;
  logic             first_row;
  logic             last_row;

  assign in_frame  = col_q < COLP_W'(cfg_i.cols);
  assign process   = accept_i && !(flush_i && in_frame);
  assign fed_n     = fed_q + 1'b1;
  assign emitted_n = emitted_q + 1'b1;
  assign emit      = fed_n >= CNT_W'(rows_i) + CNT_W'(2);
  assign last      = emit && (emitted_n >= cfg_i.total);
  assign row_wrap  = CNT_W'(row_q) + CNT_W'(1) >= CNT_W'(rows_i);

  // Position of the centre pixel of the code produced by this item.
  assign first_col = cc_q == '0;
  assign last_col  = (CNT_W + 1)'(cc_q) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(cfg_i.cols);
  assign first_row = cr_q == '0;
  assign last_row  = CNT_W'(cr_q) + CNT_W'(1) >= CNT_W'(rows_i);

  assign valid_o     = process;
  assign addr_o      = row_q;
  assign emitted_o   = emitted_q;
  assign item_o.emit = emit;
  assign item_o.last = last;
  assign item_o.mask = ~((first_col ? NB_LEFT  : '0) | (last_col ? NB_RIGHT : '0) |
                         (first_row ? NB_UP    : '0) | (last_row ? NB_DOWN  : '0));
  // Once every column is in, further items only push zeros through the window.
  assign item_o.pixel = in_frame ? pixel_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      fed_q     <= '0;
      emitted_q <= '0;
      cr_q      <= '0;
      cc_q      <= '0;
    end else if (div_i.done) begin
      cr_q <= rem_i;
      cc_q <= quo_i;
    end else if (process) begin
      if (last) begin
        row_q     <= '0;
        col_q     <= '0;
        fed_q     <= '0;
        emitted_q <= '0;
        cr_q      <= '0;
        cc_q      <= '0;
      end else begin
        if (row_wrap) begin
          row_q <= '0;
          if (col_q != '1) begin
            col_q <= col_q + 1'b1;
          end
        end else begin
          row_q <= row_q + 1'b1;
        end
        fed_q <= fed_n;
        if (emit) begin
          emitted_q <= emitted_n;
          if (last_row) begin
            cr_q <= '0;
            cc_q <= cc_q + 1'b1;
          end else begin
            cr_q <= cr_q + 1'b1;
          end
        end
      end
    end
  end

  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> !div_i.busy)
    else $error("item accepted while the position divider is running");

  a_centre_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_i.busy |-> CNT_W'(cr_q) < CNT_W'(rows_i))
    else $error("centre row out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && last) |=> (row_q == '0 && col_q == '0 && cc_q == '0))
    else $error("scan position not cleared after the last code of a frame");

endmodule

### hdl/lbp_win.sv
// Column buffer memory, 3x3 window, eight compares and the result register.
// Depends on lbp_pkg.
module lbp_win
  import lbp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int AW       = $clog2(MAX_ROWS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pipe_en_t         en_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [AW-1:0]    addr_i,
  output pipe_st_t         st_o,
  output logic             out_valid_o,
  output logic [NB_N-1:0]  code_o,
  output logic             last_o
);

  // Each entry holds {previous column, second previous column} of one row.
  logic [2*PIX_W-1:0] mem [MAX_ROWS];
  logic [2*PIX_W-1:0] rd_q;

  logic             v1_q;
  item_t            it1_q;
  logic [AW-1:0]    addr1_q;
  logic             v2_q;
  logic [NB_N-1:0]  mask2_q;
  logic             emit2_q;
  logic             last2_q;
  logic [PIX_W-1:0] win_q [WIN_N];
  logic             outv_q;
  logic [NB_N-1:0]  code_q;
  logic             last_q;

  logic            load1;
  logic            move2;
  logic            move3;
  logic [NB_N-1:0] code_d;

  assign load1 = en_i.en1 && valid_i;
  assign move2 = en_i.en2 && v1_q;
  assign move3 = en_i.en3 && v2_q && emit2_q;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      rd_q <= mem[addr_i];
    end
    if (move2) begin
      mem[addr1_q] <= {it1_q.pixel, rd_q[2*PIX_W-1:PIX_W]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      outv_q <= 1'b0;
      win_q  <= '{default: '0};
    end else begin
      if (en_i.en1) begin
        v1_q <= valid_i;
      end
      if (en_i.en2) begin
        v2_q <= v1_q;
      end
      if (move2) begin
        for (int i = 0; i < WIN_N - 3; i++) begin
          win_q[i] <= win_q[i+3];
        end
        win_q[WIN_N-3] <= rd_q[PIX_W-1:0];
        win_q[WIN_N-2] <= rd_q[2*PIX_W-1:PIX_W];
        win_q[WIN_N-1] <= it1_q.pixel;
      end
      if (en_i.en3) begin
        outv_q <= v2_q && emit2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      it1_q   <= item_i;
      addr1_q <= addr_i;
    end
    if (move2) begin
      mask2_q <= it1_q.mask;
      emit2_q <= it1_q.emit;
      last2_q <= it1_q.last;
    end
    if (move3) begin
      code_q <= code_d;
      last_q <= last2_q;
    end
  end

  always_comb begin
    for (int n = 0; n < NB_N; n++) begin
      code_d[n] = mask2_q[n] && (win_q[NB_TAP[n]] >= win_q[CENTRE_TAP]);
    end
  end

  assign st_o.v1     = v1_q;
  assign st_o.v2     = v2_q;
  assign out_valid_o = outv_q;
  assign code_o      = code_q;
  assign last_o      = last_q;

endmodule

### hdl/local_binary_pattern_3x3.sv
// Top level of the 3x3 local binary pattern block; instantiates lbp_regs, lbp_div, lbp_seq, lbp_win.
// One item per cycle while in_stall_o is low. A code passes buffer read, window shift and
// result after the item completing its neighbourhood, image_rows+1 items after its own pixel;
// flush items drain the tail. After reset and every configuration write the input stalls while
// a one-bit-per-cycle divider re-derives the centre row and column from the emitted count.
// Reset clears all control state and the window; column buffer contents stay undefined.
module local_binary_pattern_3x3
  import lbp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PIX_W-1:0]   pixel_value_i,
  input  logic               flush_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NB_N-1:0]    lbp_code_o,
  output logic               last_of_frame_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Row count needs enough bits to hold MAX_ROWS itself; the buffer address does not.
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int AW = $clog2(MAX_ROWS);

  cfg_t             cfg;
  logic [RW-1:0]    rows;
  logic             cfg_wr;
  div_st_t          div_st;
  logic [CNT_W-1:0] quo;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] emitted;
  logic             item_valid;
  item_t            item;
  logic [AW-1:0]    addr;
  pipe_st_t         pst;
  pipe_en_t         pen;
  logic             accept;

  // The pipeline has three registered stages: buffer read, window shift, result.
  // A stage advances when the one after it advances or is empty, so bubbles
  // collapse and a new item can be taken while a finished code waits downstream.
  assign pen.en3 = !out_valid_o || !out_stall_i;
  assign pen.en2 = pen.en3 || !pst.v2;
  assign pen.en1 = pen.en2 || !pst.v1;

  // While the divider runs the scan position is not known, so no item enters.
  assign in_stall_o = div_st.busy || !pen.en1;
  assign accept     = in_valid_i && !in_stall_o;

  lbp_regs #(
    .MAX_ROWS (MAX_ROWS),
    .RW       (RW)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .rows_o    (rows),
    .cfg_o     (cfg),
    .wr_o      (cfg_wr)
  );

  // A new size changes how the emitted count maps to a centre position.
  lbp_div #(
    .RW (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cfg_wr),
    .dividend_i (emitted),
    .divisor_i  (rows),
    .st_o       (div_st),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  lbp_seq #(
    .MAX_ROWS (MAX_ROWS),
    .RW       (RW),
    .AW       (AW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .flush_i   (flush_i),
    .pixel_i   (pixel_value_i),
    .rows_i    (rows),
    .cfg_i     (cfg),
    .div_i     (div_st),
    .quo_i     (quo),
    .rem_i     (rem),
    .emitted_o (emitted),
    .valid_o   (item_valid),
    .item_o    (item),
    .addr_o    (addr)
  );

  // Items that only advance the window still travel the pipeline; only
  // those that produce a code raise out_valid_o.
  lbp_win #(
    .MAX_ROWS (MAX_ROWS),
    .AW       (AW)
  ) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pen),
    .valid_i     (item_valid),
    .item_i      (item),
    .addr_i      (addr),
    .st_o        (pst),
    .out_valid_o (out_valid_o),
    .code_o      (lbp_code_o),
    .last_o      (last_of_frame_o)
  );

endmodule

### bench/tb.sv
// Self-checking bench for local_binary_pattern_3x3: pixel frames in, LBP codes out.
// Depends only on lbp_pkg and the block; all stimulus and the code predictor live here.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  localparam int MAX_ROWS      = MAX_ROWS_DEF;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 40;

  // Neighbour n as (column,row) offset from the centre pixel.
  localparam int COL_STEP [NB_N] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int ROW_STEP [NB_N] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             flush;
  } pixel_item_s;

  typedef struct packed {
    logic [NB_N-1:0] code;
    logic            last;
  } lbp_result_s;

  typedef enum int {RX_NEVER, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum int {PIX_UNIFORM, PIX_FLAT, PIX_EXTREME, PIX_NARROW} pix_style_e;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [PIX_W-1:0]   pixel_value_i   = '0;
  logic               flush_i         = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic [NB_N-1:0]    lbp_code_o;
  logic               last_of_frame_o;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [PADDR_W-1:0] paddr           = '0;
  logic [PDATA_W-1:0] pwdata          = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  local_binary_pattern_3x3 #(
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .flush_i        (flush_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .lbp_code_o     (lbp_code_o),
    .last_of_frame_o(last_of_frame_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: register copies, the two column buffers, the 3x3 window and the
  // frame position. It advances once per accepted item that is not a flush inside the frame.
  logic [ROWS_W-1:0] cfg_rows = ROWS_RESET;
  logic [COLS_W-1:0] cfg_cols = COLS_RESET;
  logic [PIX_W-1:0]  prev_col  [MAX_ROWS];
  logic [PIX_W-1:0]  prev2_col [MAX_ROWS];
  logic [PIX_W-1:0]  win       [WIN_N];
  int unsigned       row_pos        = 0;
  int unsigned       col_pos        = 0;
  int unsigned       codes_in_frame = 0;
  int unsigned       items_in_frame = 0;

  pixel_item_s pixel_items [$];  // items waiting to be offered to the block
  lbp_result_s codes_due   [$];  // codes predicted but not yet seen at the output
  pixel_item_s next_item;
  lbp_result_s due;

  logic     item_taken   = 1'b0;
  logic     sender_gaps  = 1'b0;
  int       burst_left   = 0;
  int       gap_left     = 0;
  rx_mode_e rx_mode      = RX_NEVER;
  int       rx_phase     = 0;
  int       hold_request = 0;
  int       hold_left    = 0;

  int unsigned cycle_count        = 0;
  int unsigned fail_count         = 0;
  int unsigned items_accepted     = 0;
  int unsigned codes_checked      = 0;
  int unsigned frames_done        = 0;
  int unsigned input_stall_cycles = 0;

  // Register values out of range are used saturated.
  function automatic int unsigned eff_rows();
    if (cfg_rows < ROWS_MIN) return ROWS_MIN;
    if (cfg_rows > MAX_ROWS) return MAX_ROWS;
    return cfg_rows;
  endfunction

  function automatic int unsigned eff_cols();
    if (cfg_cols < COLS_MIN) return COLS_MIN;
    return cfg_cols;
  endfunction

  // Advances the shadow by one accepted item and queues the code it releases, if any.
  task automatic predict_code(input logic [PIX_W-1:0] pix, input logic is_flush);
    int unsigned rows, cols, cr, cc, slot;
    int dc, dr, i, n;
    logic [PIX_W-1:0] v, a_old, b_old, centre;
    lbp_result_s res;
    rows = eff_rows();
    cols = eff_cols();
    // A flush inside the frame is dropped; after the frame every item drains.
    if (is_flush && col_pos < cols) return;
    v = (col_pos < cols) ? pix : '0;
    slot = row_pos % MAX_ROWS;
    a_old = prev_col[slot];
    b_old = prev2_col[slot];
    prev2_col[slot] = a_old;
    prev_col[slot] = v;
    for (i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = b_old;
    win[7] = a_old;
    win[8] = v;
    if (row_pos + 1 >= rows) begin
      row_pos = 0;
      col_pos++;
    end else begin
      row_pos++;
    end
    items_in_frame++;
    // The neighbourhood of a pixel is complete one column plus one item later.
    if (items_in_frame < rows + 2) return;
    cr = codes_in_frame % rows;
    cc = codes_in_frame / rows;
    centre = win[CENTRE_TAP];
    res.code = '0;
    for (n = 0; n < NB_N; n++) begin
      dc = COL_STEP[n];
      dr = ROW_STEP[n];
      if (dc < 0 && cc == 0) continue;
      if (dc > 0 && cc + 1 >= cols) continue;
      if (dr < 0 && cr == 0) continue;
      if (dr > 0 && cr + 1 >= rows) continue;
      if (win[(1 + dr) * 3 + 1 + dc] >= centre) res.code[n] = 1'b1;
    end
    codes_in_frame++;
    res.last = (codes_in_frame >= rows * cols);
    if (res.last) begin
      row_pos = 0;
      col_pos = 0;
      codes_in_frame = 0;
      items_in_frame = 0;
    end
    codes_due.push_back(res);
  endtask

  // Input side: prediction happens at the edge where the block takes the item.
  always @(posedge clk_i) begin
    item_taken = rst_ni && in_valid_i && !in_stall_o;
    if (item_taken) begin
      predict_code(pixel_value_i, flush_i);
      items_accepted++;
    end
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d codes still due",
               $realtime, cycle_count, codes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: each code taken is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (codes_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected code: expected none, actual code=%02h last=%0b",
                   $realtime, lbp_code_o, last_of_frame_o);
      end else begin
        due = codes_due.pop_front();
        codes_checked++;
        if (due.last) frames_done++;
        if (lbp_code_o !== due.code) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: lbp_code mismatch: expected %02h, actual %02h",
                     $realtime, due.code, lbp_code_o);
        end
        if (last_of_frame_o !== due.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: last_of_frame mismatch: expected %0b, actual %0b",
                     $realtime, due.last, last_of_frame_o);
        end
      end
    end
  end

  // Sender: holds each item until taken, then works in bursts with random gaps when enabled.
  always @(negedge clk_i) begin
    if (!in_valid_i || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_items.size() > 0) begin
        next_item = pixel_items.pop_front();
        pixel_value_i <= next_item.value;
        flush_i <= next_item.flush;
        in_valid_i <= 1'b1;
        if (sender_gaps) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(30, 1);
            gap_left = $urandom_range(8, 1);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when one is requested, otherwise its own stall pattern.
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_NEVER: begin
          out_stall_i <= 1'b0;
        end
        RX_RANDOM: begin
          out_stall_i <= ($urandom_range(99) < 35);
        end
        default: begin
          rx_phase = (rx_phase + 1) % 7;
          out_stall_i <= (rx_phase < 3);
        end
      endcase
    end
  end

  task automatic check_reg(input logic idx, input logic [PDATA_W-1:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      fail_count++;
      $display("%0t: register %0d readback: expected %08h, actual %08h",
               $realtime, idx, want, prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes one register, mirrors it in the shadow, then reads it back.
  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] word);
    logic [PDATA_W-1:0] keep;
    keep = (idx == REG_ROWS) ? ((32'd1 << ROWS_W) - 1) : ((32'd1 << COLS_W) - 1);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ROWS) cfg_rows = word[ROWS_W-1:0];
    else cfg_cols = word[COLS_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_reg(idx, word & keep);
  endtask

  // Both sizes, with junk in the unused upper bits of the data word.
  task automatic set_size(input int unsigned rows, input int unsigned cols);
    write_reg(REG_ROWS, ($urandom() & ~((32'd1 << ROWS_W) - 1)) | rows);
    write_reg(REG_COLS, ($urandom() & ~((32'd1 << COLS_W) - 1)) | cols);
  endtask

  task automatic push_item(input logic [PIX_W-1:0] value, input logic is_flush);
    pixel_items.push_back('{value: value, flush: is_flush});
  endtask

  // Frame pixels with a random texture; some flushes slip in and are ignored by the block.
  task automatic queue_pixels(input int unsigned count, input int ignored_pct);
    pix_style_e style;
    logic [PIX_W-1:0] level, v;
    int unsigned k;
    style = pix_style_e'($urandom_range(3));
    level = $urandom_range(255);
    for (k = 0; k < count; k++) begin
      case (style)
        PIX_UNIFORM: v = $urandom_range(255);
        PIX_FLAT:    v = level;
        PIX_EXTREME: v = $urandom_range(1) ? 8'hFF : 8'h00;
        default:     v = level + $urandom_range(2);
      endcase
      if ($urandom_range(99) < ignored_pct) push_item($urandom_range(255), 1'b1);
      push_item(v, 1'b0);
    end
  endtask

  // After the last pixel, rows+1 items drain the tail; pixel values there are dropped.
  task automatic queue_drain(input int unsigned rows, input logic flush_only);
    int unsigned k;
    for (k = 0; k <= rows; k++)
      push_item($urandom_range(255), flush_only ? 1'b1 : 1'(($urandom_range(1))));
  endtask

  task automatic queue_frame(input int unsigned rows, input int unsigned cols,
                             input int ignored_pct, output int unsigned counted);
    queue_pixels(rows * cols, ignored_pct);
    queue_drain(rows, 1'b0);
    counted = rows * cols + rows + 1;
  endtask

  // Idle means every item offered and every code seen, plus a settling wait for items that
  // release no code and may still be in the pipeline.
  task automatic wait_idle();
    while (pixel_items.size() != 0 || in_valid_i || codes_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned counted, random_items, rows_cfg, cols_cfg, phase_no;
    foreach (prev_col[i]) begin
      prev_col[i] = '0;
      prev2_col[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    random_items = 0;
    phase_no = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reg(REG_ROWS, ROWS_RESET);
    check_reg(REG_COLS, COLS_RESET);

    // Smallest image, no idling on either side: extremes, ties, a flush inside the frame,
    // pixels after the frame acting as flushes, and a trailing flush that starts nothing.
    set_size(3, 3);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b1);
    push_item(8'h80, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hC8, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'h09, 1'b0);
    push_item(8'h55, 1'b1);
    wait_idle();

    // Sizes below the minimum saturate to 3x3; a flat image sets every in-image neighbour.
    set_size(2, 0);
    rx_mode = RX_RANDOM;
    sender_gaps = 1'b1;
    repeat (9) push_item(8'd77, 1'b0);
    queue_drain(3, 1'b1);
    wait_idle();

    // Random frames of mostly small sizes. The first one runs without gaps while the
    // receiver holds off long enough for the block to back up and stall its input.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0:       rows_cfg = $urandom_range(2, 0);
        1:       rows_cfg = $urandom_range(64, 25);
        default: rows_cfg = $urandom_range(24, 3);
      endcase
      cols_cfg = ($urandom_range(6) == 0) ? $urandom_range(2, 0) : $urandom_range(16, 3);
      set_size(rows_cfg, cols_cfg);
      if (phase_no == 0) begin
        sender_gaps = 1'b0;
        rx_mode = RX_NEVER;
      end else begin
        sender_gaps = ($urandom_range(3) != 0);
        rx_mode = rx_mode_e'($urandom_range(2));
      end
      queue_frame(eff_rows(), eff_cols(), $urandom_range(1) ? 15 : 0, counted);
      if (phase_no == 0) hold_request = LONG_HOLD;
      random_items += counted;
      phase_no++;
      wait_idle();
    end

    // All row bits set: saturates to the deepest column buffer.
    set_size(2047, 3);
    rx_mode = RX_RANDOM;
    sender_gaps = 1'b1;
    queue_frame(eff_rows(), eff_cols(), 5, counted);
    wait_idle();

    // Column count raised mid-frame: the frame simply grows.
    set_size(4, 3);
    rx_mode = RX_PATTERN;
    queue_pixels(8, 10);
    wait_idle();
    write_reg(REG_COLS, 6);
    queue_pixels(16, 10);
    queue_drain(4, 1'b0);
    wait_idle();

    // Widest image, cut short mid-frame: the next code already passes the new pixel total,
    // so one drain item ends the frame and the remaining flushes are ignored.
    set_size(3, 65535);
    rx_mode = RX_RANDOM;
    queue_pixels(24, 0);
    wait_idle();
    write_reg(REG_COLS, 5);
    queue_drain(3, 1'b1);
    wait_idle();

    $display("Run took %0d items in %0d frames and checked %0d codes over %0d cycles.",
             items_accepted, frames_done, codes_checked, cycle_count);
    $display("Input was held back for %0d cycles; sizes ranged 3x3 to 1024 rows, 65535 cols.",
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lbp_pkg.sv
hdl/lbp_regs.sv
hdl/lbp_div.sv
hdl/lbp_seq.sv
hdl/lbp_win.sv
hdl/local_binary_pattern_3x3.sv
bench/tb.sv
